>>> hw/rtl/tmfs_pkg.sv
// ----------------------------------------------------------------------------
// tmfs_pkg
// Types and fixed constants shared by the front, back, core and bench.
// ----------------------------------------------------------------------------
package tmfs_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    localparam int PIXEL_W        = 24;
    localparam int MASK_W         = 8;
    localparam int FRAME_WIDTH_W  = 10;
    localparam int FRAME_HEIGHT_W = 9;
    localparam int SIZE_W         = 19;
    localparam int CFG_DATA_W     = 10;
    localparam int CFG_INDEX_W    = 1;
    localparam int PROD_W         = 16;
    localparam int IDX_W          = 8;
    localparam int AGE_W          = 5;

    localparam int RESET_FRAME_WIDTH  = 640;
    localparam int RESET_FRAME_HEIGHT = 480;

    // x / 255 equals (x * 0x8081) >> 23 for every 16-bit x.
    localparam int RECIP_W     = 17;
    localparam int RECIP_PROD_W = 33;
    localparam logic [RECIP_W-1:0] RECIP_255 = 17'h08081;
    localparam int RECIP_SHIFT = 23;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

endpackage

>>> hw/rtl/tmfs_ram.sv
// ----------------------------------------------------------------------------
// tmfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tmfs_ram #(
    parameter int WIDTH = 24,
    parameter longint unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tmfs_queue.sv
// ----------------------------------------------------------------------------
// tmfs_queue
// Short register queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module tmfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The front must never offer an item while the queue reports full.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("tmfs_queue: push while full");

endmodule

>>> hw/rtl/tmfs_front.sv
// ----------------------------------------------------------------------------
// tmfs_front
// Accepts pixels, tracks frame position and the history ring, and classifies
// each pixel into a queue entry for the back end.
// ----------------------------------------------------------------------------
module tmfs_front
    import tmfs_pkg::*;
#(
    parameter int HISTORY_FRAMES = 32,
    parameter int MAX_WIDTH      = 640,
    parameter int MAX_HEIGHT     = 480
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic [MASK_W-1:0]      mask,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   push,
    output logic [PIXEL_W + PROD_W + 2 * $clog2(HISTORY_FRAMES)
                  + ((MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)
                  : 0]             push_data,
    input  logic                   q_full
);

    localparam int FRAME_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int SLOT_W      = $clog2(HISTORY_FRAMES);
    localparam int HELD_W      = $clog2(HISTORY_FRAMES + 1);
    localparam int POS_W       = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;
    localparam int CMP_W       = ((POS_W > SIZE_W) ? POS_W : SIZE_W) + 1;
    localparam int RST_W       = (MAX_WIDTH < RESET_FRAME_WIDTH) ? MAX_WIDTH
                                                                  : RESET_FRAME_WIDTH;
    localparam int RST_H       = (MAX_HEIGHT < RESET_FRAME_HEIGHT) ? MAX_HEIGHT
                                                                    : RESET_FRAME_HEIGHT;

    logic [FRAME_WIDTH_W-1:0]  width_reg, width_next;
    logic [FRAME_HEIGHT_W-1:0] height_reg, height_next;
    logic [SIZE_W-1:0]         size_reg, size_next;
    logic [FRAME_WIDTH_W-1:0]  width_clamped;
    logic [FRAME_HEIGHT_W-1:0] height_clamped;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [SLOT_W-1:0] held_m1;
    logic [PROD_W-1:0] prod;
    logic              last;
    logic              accept;
    pixel_t            pix;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = accept;

    // A register write must already hold for the next pixel, so the frame
    // size is formed from the values being written.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data[FRAME_HEIGHT_W-1:0];
                default:          width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_next == '0)
        begin
            width_clamped = FRAME_WIDTH_W'(1);
        end
        else if ({22'd0, width_next} > 32'(MAX_WIDTH))
        begin
            width_clamped = FRAME_WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = width_next;
        end

        if (height_next == '0)
        begin
            height_clamped = FRAME_HEIGHT_W'(1);
        end
        else if ({23'd0, height_next} > 32'(MAX_HEIGHT))
        begin
            height_clamped = FRAME_HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            height_clamped = height_next;
        end

        size_next = SIZE_W'({9'd0, width_clamped} * {10'd0, height_clamped});
    end

    // Frame bookkeeping for the pixel being accepted.
    always_comb
    begin
        slot_next = slot_reg;
        held_next = held_reg;
        if (pos_reg == '0)
        begin
            if (held_reg == '0)
            begin
                slot_next = '0;
                held_next = HELD_W'(1);
            end
            else
            begin
                slot_next = (slot_reg == SLOT_W'(HISTORY_FRAMES - 1)) ? '0
                                                                       : slot_reg + 1'b1;
                held_next = (held_reg == HELD_W'(HISTORY_FRAMES)) ? held_reg
                                                                   : held_reg + 1'b1;
            end
        end
        held_m1  = SLOT_W'(held_next - HELD_W'(1));
        prod     = PROD_W'(mask) * PROD_W'(held_m1);
        last     = (CMP_W'(pos_reg) + CMP_W'(1)) >= CMP_W'(size_reg);
        pos_next = last ? '0 : pos_reg + 1'b1;
    end

    assign pix.red    = red;
    assign pix.green  = green;
    assign pix.blue   = blue;
    assign push_data  = {pix, prod, held_m1, slot_next, pos_reg, last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_W'(RESET_FRAME_WIDTH);
            height_reg <= FRAME_HEIGHT_W'(RESET_FRAME_HEIGHT);
            size_reg   <= SIZE_W'(RST_W * RST_H);
            pos_reg    <= '0;
            slot_reg   <= '0;
            held_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            size_reg   <= size_next;
            if (accept)
            begin
                pos_reg  <= pos_next;
                slot_reg <= slot_next;
                held_reg <= held_next;
            end
        end
    end

    // Once a pixel has been taken the ring holds between one and all frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (held_reg != '0) && (held_reg <= HELD_W'(HISTORY_FRAMES)))
        else $error("tmfs_front: frame count out of range");

endmodule

>>> hw/rtl/tmfs_back.sv
// ----------------------------------------------------------------------------
// tmfs_back
// Executes queued pixels: frame index, slot and address, history write and
// read, and the output register.
// ----------------------------------------------------------------------------
module tmfs_back
    import tmfs_pkg::*;
#(
    parameter int HISTORY_FRAMES = 32,
    parameter int MAX_WIDTH      = 640,
    parameter int MAX_HEIGHT     = 480
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [PIXEL_W + PROD_W + 2 * $clog2(HISTORY_FRAMES)
                  + ((MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1)
                  : 0]        q_data,
    input  logic              q_empty,
    output logic              q_pop,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic [AGE_W-1:0]  chosen_age_index,
    output logic              last_of_frame,
    output logic              out_valid,
    input  logic              out_stall
);

    localparam int FRAME_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int SLOT_W      = $clog2(HISTORY_FRAMES);
    localparam int SUM_W       = SLOT_W + 2;
    localparam int POS_W       = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;
    localparam longint unsigned RAM_DEPTH = longint'(HISTORY_FRAMES) * longint'(FRAME_CELLS);
    localparam int ADDR_W      = $clog2(RAM_DEPTH);

    // Queue entry fields.
    pixel_t                  q_pix;
    logic [PROD_W-1:0]       q_prod;
    logic [SLOT_W-1:0]       q_hm1;
    logic [SLOT_W-1:0]       q_slot;
    logic [POS_W-1:0]        q_pos;
    logic                    q_last;
    logic [RECIP_PROD_W-1:0] recip_prod;

    assign {q_pix, q_prod, q_hm1, q_slot, q_pos, q_last} = q_data;

    logic adv;

    // Stage A: frame index.
    logic              a_valid_reg;
    pixel_t            a_pix_reg;
    logic [IDX_W-1:0]  a_idx_reg;
    logic [SLOT_W-1:0] a_hm1_reg;
    logic [SLOT_W-1:0] a_slot_reg;
    logic [POS_W-1:0]  a_pos_reg;
    logic              a_last_reg;

    // Stage B: slot of the chosen frame.
    logic              b_valid_reg;
    pixel_t            b_pix_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic              b_hit_reg;
    logic [SLOT_W-1:0] b_rslot_reg;
    logic [SLOT_W-1:0] b_wslot_reg;
    logic [POS_W-1:0]  b_pos_reg;
    logic              b_last_reg;
    logic [SUM_W-1:0]  slot_sum;
    logic [SLOT_W-1:0] rslot;

    // Stage C: history addresses.
    logic              c_valid_reg;
    pixel_t            c_pix_reg;
    logic [IDX_W-1:0]  c_idx_reg;
    logic              c_hit_reg;
    logic [ADDR_W-1:0] c_raddr_reg;
    logic [ADDR_W-1:0] c_waddr_reg;
    logic              c_last_reg;

    // Stage D: history read in flight.
    logic              d_valid_reg;
    pixel_t            d_pix_reg;
    logic [IDX_W-1:0]  d_idx_reg;
    logic              d_hit_reg;
    logic              d_last_reg;
    logic [PIXEL_W-1:0] ram_rdata;
    logic              ram_access;

    // Output register.
    logic              out_valid_reg;
    pixel_t            out_pix_reg;
    logic [AGE_W-1:0]  out_idx_reg;
    logic              out_last_reg;

    assign adv        = !out_valid_reg || !out_stall;
    assign q_pop      = adv && !q_empty;
    assign ram_access = adv && c_valid_reg;

    assign recip_prod = RECIP_PROD_W'(q_prod) * RECIP_PROD_W'(RECIP_255);

    // Oldest slot plus index, modulo the ring size; the sum stays below twice it.
    assign slot_sum = SUM_W'(a_slot_reg) + SUM_W'(HISTORY_FRAMES) - SUM_W'(a_hm1_reg)
                    + SUM_W'(a_idx_reg);
    assign rslot    = (slot_sum >= SUM_W'(HISTORY_FRAMES))
                    ? SLOT_W'(slot_sum - SUM_W'(HISTORY_FRAMES))
                    : SLOT_W'(slot_sum);

    tmfs_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (RAM_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_access),
        .waddr (c_waddr_reg),
        .wdata (c_pix_reg),
        .re    (ram_access),
        .raddr (c_raddr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= !q_empty;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_pix_reg   <= q_pix;
            a_idx_reg   <= recip_prod[RECIP_SHIFT +: IDX_W];
            a_hm1_reg   <= q_hm1;
            a_slot_reg  <= q_slot;
            a_pos_reg   <= q_pos;
            a_last_reg  <= q_last;

            b_pix_reg   <= a_pix_reg;
            b_idx_reg   <= a_idx_reg;
            b_hit_reg   <= (a_idx_reg >= IDX_W'(a_hm1_reg));
            b_rslot_reg <= rslot;
            b_wslot_reg <= a_slot_reg;
            b_pos_reg   <= a_pos_reg;
            b_last_reg  <= a_last_reg;

            c_pix_reg   <= b_pix_reg;
            c_idx_reg   <= b_idx_reg;
            c_hit_reg   <= b_hit_reg;
            c_raddr_reg <= ADDR_W'(b_rslot_reg) * ADDR_W'(FRAME_CELLS) + ADDR_W'(b_pos_reg);
            c_waddr_reg <= ADDR_W'(b_wslot_reg) * ADDR_W'(FRAME_CELLS) + ADDR_W'(b_pos_reg);
            c_last_reg  <= b_last_reg;

            d_pix_reg   <= c_pix_reg;
            d_idx_reg   <= c_idx_reg;
            d_hit_reg   <= c_hit_reg;
            d_last_reg  <= c_last_reg;

            // The newest frame is the pixel itself; older frames come from history.
            out_pix_reg  <= d_hit_reg ? d_pix_reg : pixel_t'(ram_rdata);
            out_idx_reg  <= d_idx_reg[AGE_W-1:0];
            out_last_reg <= d_last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_red          = out_pix_reg.red;
    assign out_green        = out_pix_reg.green;
    assign out_blue         = out_pix_reg.blue;
    assign chosen_age_index = out_idx_reg;
    assign last_of_frame    = out_last_reg;

    // The scaled index never points past the newest frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> (a_idx_reg <= IDX_W'(a_hm1_reg)))
        else $error("tmfs_back: frame index beyond newest frame");

    // A history read never targets the entry being written in the same transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && !c_hit_reg) |-> (c_raddr_reg != c_waddr_reg))
        else $error("tmfs_back: read collides with current write");

    // A stalled result keeps its frame marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_last_reg))
        else $error("tmfs_back: output register changed under stall");

endmodule

>>> hw/rtl/temporal_mask_frame_select_core.sv
// ----------------------------------------------------------------------------
// temporal_mask_frame_select_core
// Time-displacement pixel effect: each pixel is replaced by the pixel at the
// same position of a past frame chosen by its mask value.
//
// Pixels enter in raster order on the input channel (in_valid / in_stall)
// with red, green, blue and mask; one result leaves per pixel on the output
// channel (out_valid / out_stall). A transfer happens when valid is high and
// stall is low. frame_width and frame_height are written through the
// configuration channel (cfg_valid / cfg_ready, index 0 and 1) while idle.
// Every pixel is written into the history memory, and each result is read
// from it at the frame picked by mask, or forwarded when the newest frame
// is picked. While the output is not stalled, one pixel is accepted and one
// result delivered per cycle, limited by the single write port and single
// read port of the history memory. Each result passes through the queue,
// stages A to D and the output register. When the receiver stalls, the output
// register holds and a four-entry queue keeps taking pixels until it fills,
// then in_stall rises. Reset empties the history ring, restarts at the first
// pixel of a frame and restores the 640 by 480 frame size; the history memory
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module temporal_mask_frame_select_core
    import tmfs_pkg::*;
#(
    parameter int HISTORY_FRAMES = 32,
    parameter int MAX_WIDTH      = 640,
    parameter int MAX_HEIGHT     = 480
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic [MASK_W-1:0]      mask,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    output logic [AGE_W-1:0]       chosen_age_index,
    output logic                   last_of_frame,
    output logic                   out_valid,
    input  logic                   out_stall
);

    localparam int FRAME_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int SLOT_W      = $clog2(HISTORY_FRAMES);
    localparam int POS_W       = (FRAME_CELLS > 1) ? $clog2(FRAME_CELLS) : 1;
    localparam int ENTRY_W     = PIXEL_W + PROD_W + 2 * SLOT_W + POS_W + 1;

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               q_full;
    logic               q_pop;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_data;

    tmfs_front #(
        .HISTORY_FRAMES (HISTORY_FRAMES),
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .mask      (mask),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    tmfs_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    tmfs_back #(
        .HISTORY_FRAMES (HISTORY_FRAMES),
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_data           (q_data),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .chosen_age_index (chosen_age_index),
        .last_of_frame    (last_of_frame),
        .out_valid        (out_valid),
        .out_stall        (out_stall)
    );

endmodule

>>> tb/sv/temporal_mask_frame_select_core_tb.sv
// ----------------------------------------------------------------------------
// temporal_mask_frame_select_core_tb
// Self-checking bench for the time-displacement frame select core. A short
// table of directed pixels and register writes comes first. Random frame
// sizes and random pixel streams follow. Both channels idle at random; each
// result is compared with the bench's frame-history predictor or a hand value.
// ----------------------------------------------------------------------------
module temporal_mask_frame_select_core_tb;
    import tmfs_pkg::*;

    localparam int RING    = 32;
    localparam int MAX_W   = 640;
    localparam int MAX_H   = 480;
    localparam int CELLS   = MAX_W * MAX_H;
    localparam int HOLD_AT = 500;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        pixel_t           px;
        logic [AGE_W-1:0] age;
        logic             last;
    } frame_result_t;

    typedef enum logic {STEP_PIXEL, STEP_CONFIG} step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        cfg_reg_t              reg_sel;
        logic [CFG_DATA_W-1:0] value;
        pixel_t                px;
        logic [MASK_W-1:0]     sel;
        logic                  by_hand;
        frame_result_t         want;
    } directed_step_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] width;
        logic [CFG_DATA_W-1:0] height;
        logic [11:0]           count;
    } size_phase_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic [MASK_W-1:0]     mask;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [AGE_W-1:0]      chosen_age_index;
    logic                  last_of_frame;
    logic                  out_valid;
    logic                  out_stall = 1'b0;

    // Predictor state: frame ring, raster position and register copies.
    pixel_t        history [int];
    int            newest_slot = 0;
    int            frames_held = 0;
    int            raster_pos  = 0;
    int            reg_width   = RESET_FRAME_WIDTH;
    int            reg_height  = RESET_FRAME_HEIGHT;
    frame_result_t awaited_results [$];

    int            pixels_sent  = 0;
    int            results_seen = 0;
    int            mismatches   = 0;
    int            hold_left    = 0;
    logic          hold_done    = 1'b0;
    frame_result_t seen;
    frame_result_t oldest_wanted;

    directed_step_t directed_steps [0:20] = '{
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h000000, 8'h00, 1'b1, '{24'h000000, 5'd0, 1'b0}},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'hFFFFFF, 8'hFF, 1'b1, '{24'hFFFFFF, 5'd0, 1'b0}},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h80017F, 8'h80, 1'b1, '{24'h80017F, 5'd0, 1'b0}},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h5AA5C3, 8'h01, 1'b1, '{24'h5AA5C3, 5'd0, 1'b0}},
        // Shrink to a single pixel while in the middle of the first frame.
        '{STEP_CONFIG, REG_FRAME_WIDTH,  10'd0,    24'h000000, 8'h00, 1'b0, '0},
        '{STEP_CONFIG, REG_FRAME_HEIGHT, 10'd0,    24'h000000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h112233, 8'hFF, 1'b1, '{24'h112233, 5'd0, 1'b1}},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h445566, 8'h00, 1'b1, '{24'h000000, 5'd0, 1'b1}},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h778899, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'hAABBCC, 8'h7F, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'hDDEEF0, 8'h80, 1'b0, '0},
        // Width beyond the maximum clamps to a full line.
        '{STEP_CONFIG, REG_FRAME_WIDTH,  10'd1023, 24'h000000, 8'h00, 1'b0, '0},
        '{STEP_CONFIG, REG_FRAME_HEIGHT, 10'd1,    24'h000000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h0F0F0F, 8'h00, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'hF0F0F0, 8'hFF, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h123456, 8'h00, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h654321, 8'd40, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'h00FF00, 8'd50, 1'b0, '0},
        // Height beyond the maximum, with the unused top data bit set.
        '{STEP_CONFIG, REG_FRAME_WIDTH,  10'd1,    24'h000000, 8'h00, 1'b0, '0},
        '{STEP_CONFIG, REG_FRAME_HEIGHT, 10'd1023, 24'h000000, 8'h00, 1'b0, '0},
        '{STEP_PIXEL,  REG_FRAME_WIDTH,  10'd0,    24'hFF00FF, 8'hFF, 1'b0, '0}
    };

    size_phase_t size_phases [0:7] = '{
        '{10'd2,    10'd3,    12'd400},
        '{10'd0,    10'd0,    12'd60},
        '{10'd5,    10'd4,    12'd400},
        '{10'd1023, 10'd1,    12'd100},
        '{10'd3,    10'd2,    12'd300},
        '{10'd1,    10'd1023, 12'd60},
        '{10'd7,    10'd3,    12'd300},
        '{10'd2,    10'd1,    12'd280}
    };

    temporal_mask_frame_select_core #(
        .HISTORY_FRAMES(RING),
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .red(red),
        .green(green),
        .blue(blue),
        .mask(mask),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .out_red(out_red),
        .out_green(out_green),
        .out_blue(out_blue),
        .chosen_age_index(chosen_age_index),
        .last_of_frame(last_of_frame),
        .out_valid(out_valid),
        .out_stall(out_stall)
    );

    always #5 clk = ~clk;

    // Ring slot and frame count that the next pixel will see.
    function automatic void ring_on_arrival(output int slot, output int held);
        slot = newest_slot;
        held = frames_held;
        if (raster_pos == 0)
        begin
            if (frames_held == 0)
            begin
                slot = 0;
                held = 1;
            end
            else
            begin
                slot = (newest_slot + 1) % RING;
                held = (frames_held < RING) ? frames_held + 1 : RING;
            end
        end
    endfunction

    // History key of the chosen frame at the current position, or -1 when
    // the newest frame is chosen and the pixel is forwarded.
    function automatic int source_key(int idx, int slot, int held);
        int oldest;
        if (idx + 1 >= held)
            return -1;
        oldest = (slot + RING - (held - 1)) % RING;
        return ((oldest + idx) % RING) * CELLS + raster_pos;
    endfunction

    function automatic frame_result_t predict_pixel(pixel_t px, logic [MASK_W-1:0] sel);
        int            w;
        int            h;
        int            idx;
        int            key;
        frame_result_t res;
        w = (reg_width < 1) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
        h = (reg_height < 1) ? 1 : ((reg_height > MAX_H) ? MAX_H : reg_height);
        ring_on_arrival(newest_slot, frames_held);
        history[newest_slot * CELLS + raster_pos] = px;
        idx = int'(sel) * (frames_held - 1) / 255;
        key = source_key(idx, newest_slot, frames_held);
        res.px = (key < 0) ? px : history[key];
        res.age = AGE_W'(idx);
        res.last = (raster_pos + 1 >= w * h);
        raster_pos = res.last ? 0 : raster_pos + 1;
        return res;
    endfunction

    // Random mask that never reads a history entry left unwritten since reset.
    function automatic logic [MASK_W-1:0] pick_mask();
        int                slot;
        int                held;
        int                key;
        logic [MASK_W-1:0] sel;
        ring_on_arrival(slot, held);
        for (int tries = 0; tries < 8; tries++)
        begin
            case ($urandom_range(9))
                0: sel = '0;
                1: sel = '1;
                default: sel = MASK_W'($urandom);
            endcase
            key = source_key(int'(sel) * (held - 1) / 255, slot, held);
            if (key < 0 || history.exists(key))
                return sel;
        end
        return '1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("mismatch on result %0d: %s is %0d, expected %0d",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_pixel(input pixel_t px, input logic [MASK_W-1:0] sel,
                              input logic by_hand, input frame_result_t hand_result);
        frame_result_t predicted;
        if (pixels_sent < 1000 || pixels_sent >= 1300)
        begin
            while ($urandom_range(99) < 10)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        red      <= px.red;
        green    <= px.green;
        blue     <= px.blue;
        mask     <= sel;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_pixel(px, sel);
        awaited_results.insert(awaited_results.size(), by_hand ? hand_result : predicted);
        pixels_sent++;
    endtask

    // Stop offering pixels until every expected result has been taken.
    task automatic settle_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
        cfg_index <= sel;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (sel)
            REG_FRAME_WIDTH:  reg_width  = int'(value[FRAME_WIDTH_W-1:0]);
            REG_FRAME_HEIGHT: reg_height = int'(value[FRAME_HEIGHT_W-1:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Receiver: random stalls, one long hold-off that backs up the input,
    // and a stretch with no stalls at all.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (results_seen >= 1100 && results_seen < 1400)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 10);
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{'{out_red, out_green, out_blue}, chosen_age_index, last_of_frame};
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected, out_red", seen.px.red, 0);
            else
            begin
                oldest_wanted = awaited_results.pop_front();
                if (seen.px.red !== oldest_wanted.px.red)
                    report_mismatch("out_red", seen.px.red, oldest_wanted.px.red);
                if (seen.px.green !== oldest_wanted.px.green)
                    report_mismatch("out_green", seen.px.green, oldest_wanted.px.green);
                if (seen.px.blue !== oldest_wanted.px.blue)
                    report_mismatch("out_blue", seen.px.blue, oldest_wanted.px.blue);
                if (seen.age !== oldest_wanted.age)
                    report_mismatch("chosen_age_index", seen.age, oldest_wanted.age);
                if (seen.last !== oldest_wanted.last)
                    report_mismatch("last_of_frame", seen.last, oldest_wanted.last);
            end
            results_seen <= results_seen + 1;
        end
    end

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        pixel_t px;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= '0;
        red       <= '0;
        green     <= '0;
        blue      <= '0;
        mask      <= '0;
        in_valid  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_CONFIG)
            begin
                settle_results();
                write_reg(directed_steps[i].reg_sel, directed_steps[i].value);
            end
            else
                send_pixel(directed_steps[i].px, directed_steps[i].sel,
                           directed_steps[i].by_hand, directed_steps[i].want);
        end

        foreach (size_phases[p])
        begin
            settle_results();
            write_reg(REG_FRAME_WIDTH, size_phases[p].width);
            write_reg(REG_FRAME_HEIGHT, size_phases[p].height);
            for (int n = 0; n < int'(size_phases[p].count); n++)
            begin
                // One pause where the sender waits for the pipeline to empty.
                if (pixels_sent == 700)
                    settle_results();
                px = 24'($urandom);
                send_pixel(px, pick_mask(), 1'b0, '0);
            end
        end

        settle_results();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> temporal_mask_frame_select_core.f
hw/rtl/tmfs_pkg.sv
hw/rtl/tmfs_ram.sv
hw/rtl/tmfs_queue.sv
hw/rtl/tmfs_front.sv
hw/rtl/tmfs_back.sv
hw/rtl/temporal_mask_frame_select_core.sv
tb/sv/temporal_mask_frame_select_core_tb.sv
